@@ hdl/hrlt_pkg.sv @@
// ----------------------------------------------------------------------------
// hrlt_pkg: shared types and constants for the HTTP response length tracker
// Holds the header key text, the counter width and the result beat layout.
// ----------------------------------------------------------------------------
`default_nettype none

package hrlt_pkg;

  // Width of the internal length accumulator and payload counter
  localparam int COUNT_BITS = 31;
  localparam int OUT_BITS   = 31;
  localparam int KEY_LEN    = 16;
  localparam int POS_BITS   = $clog2(KEY_LEN + 1);
  localparam int IDX_BITS   = $clog2(KEY_LEN);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [OUT_BITS-1:0]   OUT_MAX = '1;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_SP = 8'h20;
  localparam logic [7:0] CHAR_HT = 8'h09;
  localparam logic [7:0] CHAR_VT = 8'h0B;
  localparam logic [7:0] CHAR_FF = 8'h0C;
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;

  // "Content-Length: "
  localparam logic [7:0] KEY_TEXT [KEY_LEN] = '{
    8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
    8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20
  };

  typedef enum logic [1:0] {
    PH_MATCH  = 2'd0,
    PH_BLANKS = 2'd1,
    PH_DIGITS = 2'd2,
    PH_IGNORE = 2'd3
  } phase_t;

  // CR LF CR LF progress
  typedef enum logic [2:0] {
    TM_NONE   = 3'd0,
    TM_CR1    = 3'd1,
    TM_LF1    = 3'd2,
    TM_CR2    = 3'd3,
    TM_LF2    = 3'd4
  } term_t;

  typedef struct packed {
    logic                length_known;
    logic [OUT_BITS-1:0] content_length;
    logic                header_done;
    logic [OUT_BITS-1:0] payload_count;
    logic                is_payload;
    logic                complete;
  } result_t;

  function automatic logic [OUT_BITS-1:0] clip_out(input logic [COUNT_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    if (w > 64'(OUT_MAX)) begin
      return OUT_MAX;
    end
    return w[OUT_BITS-1:0];
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SP) || (c == CHAR_HT) || (c == CHAR_LF) ||
           (c == CHAR_VT) || (c == CHAR_FF);
  endfunction

endpackage

`default_nettype wire

@@ hdl/http_response_length_tracker.sv @@
// ----------------------------------------------------------------------------
// http_response_length_tracker: Content-Length and payload byte tracker
// Parses the Content-Length header of one HTTP response and counts payload.
// ----------------------------------------------------------------------------
// Usage: feed the received response one byte per beat on the input channel
// (in_valid / in_stall, data_byte, new_response). Raise new_response on the
// first byte of a response to clear all tracking state before that byte.
// Every input beat yields exactly one result beat on the output channel
// (out_valid / out_stall) showing the state after that byte: the parsed
// length, the end-of-headers flag, the payload count and completion.
// Throughput is one byte per clock while in_stall is low, limited by the
// state update (a multiply-by-ten add and compare on the accumulator).
// The output register is backed by one skid
// entry, so a byte is still taken in the cycle the receiver first stalls;
// in_stall rises only once the skid entry is occupied and depends on no
// combinational path from out_stall.
// Reset (rst, synchronous) clears the tracking state and empties both the
// output register and the skid entry.
// ----------------------------------------------------------------------------
`default_nettype none

module http_response_length_tracker
  import hrlt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          data_byte,
  input  wire logic                new_response,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     length_known,
  output logic [OUT_BITS-1:0]      content_length,
  output logic                     header_done,
  output logic [OUT_BITS-1:0]      payload_count,
  output logic                     is_payload,
  output logic                     complete
);

  // tracking state
  logic [POS_BITS-1:0]   match_position, match_position_next;
  phase_t                digit_phase, digit_phase_next;
  logic [COUNT_BITS-1:0] length_accumulator, length_accumulator_next;
  logic                  length_found, length_found_next;
  term_t                 terminator_progress, terminator_progress_next;
  logic                  headers_ended, headers_ended_next;
  logic [COUNT_BITS-1:0] body_count, body_count_next;

  // output register and skid entry
  result_t result_reg, skid_reg, result_next;
  logic    skid_valid;

  logic accept, take;

  // effective state after an optional clear
  logic [POS_BITS-1:0]   cur_pos;
  phase_t                cur_phase;
  logic [COUNT_BITS-1:0] cur_acc;
  logic                  cur_found;
  term_t                 cur_term;
  logic                  cur_ended;
  logic [COUNT_BITS-1:0] cur_body;

  logic [COUNT_BITS+3:0] acc_times_ten;
  logic [3:0]            digit_val;
  logic                  is_digit;
  logic [COUNT_BITS-1:0] len_value;

  assign accept   = in_valid & ~in_stall;
  assign take     = out_valid & ~out_stall;
  assign in_stall = skid_valid;

  assign is_digit  = (data_byte >= CHAR_0) && (data_byte <= CHAR_9);
  assign digit_val = 4'(data_byte - CHAR_0);

  always_comb begin
    cur_pos   = new_response ? '0 : match_position;
    cur_phase = new_response ? PH_MATCH : digit_phase;
    cur_acc   = new_response ? '0 : length_accumulator;
    cur_found = new_response ? 1'b0 : length_found;
    cur_term  = new_response ? TM_NONE : terminator_progress;
    cur_ended = new_response ? 1'b0 : headers_ended;
    cur_body  = new_response ? '0 : body_count;

    // acc*10 + d, saturated past the counter range
    acc_times_ten = ((COUNT_BITS+4)'(cur_acc) << 3) + ((COUNT_BITS+4)'(cur_acc) << 1)
                    + (COUNT_BITS+4)'(digit_val);

    match_position_next     = cur_pos;
    digit_phase_next        = cur_phase;
    length_accumulator_next = cur_acc;
    length_found_next       = cur_found;

    if (!cur_found) begin
      if (cur_phase == PH_MATCH) begin
        if ((cur_pos < POS_BITS'(KEY_LEN)) &&
            (data_byte == KEY_TEXT[cur_pos[IDX_BITS-1:0]])) begin
          match_position_next = cur_pos + 1'b1;
        end else begin
          match_position_next = (data_byte == KEY_TEXT[0]) ? POS_BITS'(1) : '0;
        end
        if (match_position_next >= POS_BITS'(KEY_LEN)) begin
          digit_phase_next = PH_BLANKS;
        end
      end else if (data_byte == CHAR_CR) begin
        length_found_next = 1'b1;
      end else if (cur_phase != PH_IGNORE) begin
        if (is_digit) begin
          if (acc_times_ten > (COUNT_BITS+4)'(CNT_MAX)) begin
            length_accumulator_next = CNT_MAX;
          end else begin
            length_accumulator_next = acc_times_ten[COUNT_BITS-1:0];
          end
          digit_phase_next = PH_DIGITS;
        end else if (!(cur_phase == PH_BLANKS && is_blank(data_byte))) begin
          digit_phase_next = PH_IGNORE;
        end
      end
    end

    terminator_progress_next = cur_term;
    headers_ended_next       = cur_ended;
    body_count_next          = cur_body;
    if (cur_ended) begin
      if (cur_body != CNT_MAX) begin
        body_count_next = cur_body + 1'b1;
      end
    end else begin
      case (cur_term)
        TM_NONE, TM_LF1:
          terminator_progress_next = (data_byte == CHAR_CR) ? term_t'(cur_term + 3'd1)
                                                            : TM_NONE;
        TM_CR1, TM_CR2:
          if (data_byte == CHAR_LF) begin
            terminator_progress_next = term_t'(cur_term + 3'd1);
          end else begin
            terminator_progress_next = (data_byte == CHAR_CR) ? TM_CR1 : TM_NONE;
          end
        default:
          terminator_progress_next = (data_byte == CHAR_CR) ? TM_CR1 : TM_NONE;
      endcase
      if (terminator_progress_next == TM_LF2) begin
        headers_ended_next = 1'b1;
      end
    end

    len_value = length_found_next ? length_accumulator_next : '0;
    result_next.length_known   = length_found_next;
    result_next.content_length = clip_out(len_value);
    result_next.header_done    = headers_ended_next;
    result_next.payload_count  = clip_out(body_count_next);
    result_next.is_payload     = cur_ended;
    result_next.complete       = length_found_next & headers_ended_next &
                                 (body_count_next >= len_value);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_position      <= '0;
      digit_phase         <= PH_MATCH;
      length_accumulator  <= '0;
      length_found        <= 1'b0;
      terminator_progress <= TM_NONE;
      headers_ended       <= 1'b0;
      body_count          <= '0;
    end else if (accept) begin
      match_position      <= match_position_next;
      digit_phase         <= digit_phase_next;
      length_accumulator  <= length_accumulator_next;
      length_found        <= length_found_next;
      terminator_progress <= terminator_progress_next;
      headers_ended       <= headers_ended_next;
      body_count          <= body_count_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        result_reg <= skid_reg;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (accept) begin
        result_reg <= result_next;
        out_valid  <= 1'b1;
      end else begin
        out_valid  <= 1'b0;
      end
    end else if (accept) begin
      skid_reg   <= result_next;
      skid_valid <= 1'b1;
    end
  end

  assign length_known   = result_reg.length_known;
  assign content_length = result_reg.content_length;
  assign header_done    = result_reg.header_done;
  assign payload_count  = result_reg.payload_count;
  assign is_payload     = result_reg.is_payload;
  assign complete       = result_reg.complete;

endmodule

`default_nettype wire

@@ hdl/hrlt_checker.sv @@
// ----------------------------------------------------------------------------
// hrlt_checker: port-level checks for the HTTP response length tracker
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module hrlt_checker
  import hrlt_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic                length_known,
  input wire logic [OUT_BITS-1:0] content_length,
  input wire logic                header_done,
  input wire logic [OUT_BITS-1:0] payload_count,
  input wire logic                is_payload,
  input wire logic                complete
);

  // a held result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // input backs up only once the output side is full
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  a_complete_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && complete |-> length_known && header_done &&
                              (payload_count >= content_length))
    else $error("complete without length, header end or enough payload");

  a_payload_after_hdr: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_payload |-> header_done)
    else $error("payload byte before header end");

  a_len_zero_unknown: assert property (@(posedge clk) disable iff (rst)
    out_valid && !length_known |-> content_length == '0)
    else $error("nonzero length before it is known");

endmodule

bind http_response_length_tracker hrlt_checker u_hrlt_checker (.*);

`default_nettype wire

@@ tb/sv/http_response_length_tracker_tb.sv @@
// ----------------------------------------------------------------------------
// http_response_length_tracker_tb: self-checking bench for the length tracker
// Runs a directed byte table, then random HTTP-like responses (valid headers,
// corrupted keys, overflowing lengths, noise) through the tracker. Every
// result beat is checked field by field against an in-bench predictor (or a
// fixed beat for some directed rows), under three idle/stall mixes on the two channels.
// ----------------------------------------------------------------------------
module http_response_length_tracker_tb;
  import hrlt_pkg::*;

  localparam int RANDOM_BYTES = 1750;
  localparam int TOTAL_BYTES  = RANDOM_BYTES + 25;

  typedef struct {
    logic [7:0] data;
    logic       clear;
    logic       typed;
    result_t    want;
  } dir_row_t;

  localparam result_t R_ZERO = '0;
  localparam result_t R_LEN9 = '{length_known: 1'b1, content_length: 31'd9,
                                 header_done: 1'b0, payload_count: 31'd0,
                                 is_payload: 1'b0, complete: 1'b0};
  localparam result_t R_HDR9 = '{length_known: 1'b1, content_length: 31'd9,
                                 header_done: 1'b1, payload_count: 31'd0,
                                 is_payload: 1'b0, complete: 1'b0};
  localparam result_t R_BODY1 = '{length_known: 1'b1, content_length: 31'd9,
                                  header_done: 1'b1, payload_count: 31'd1,
                                  is_payload: 1'b1, complete: 1'b0};

  // extremes, the key, a skipped tab, one digit, trailing text, terminator
  dir_row_t dir_table [25] = '{
    '{8'hFF, 1'b1, 1'b1, R_ZERO},
    '{"C", 1'b1, 1'b0, R_ZERO}, '{"o", 1'b0, 1'b0, R_ZERO},
    '{"n", 1'b0, 1'b0, R_ZERO}, '{"t", 1'b0, 1'b0, R_ZERO},
    '{"e", 1'b0, 1'b0, R_ZERO}, '{"n", 1'b0, 1'b0, R_ZERO},
    '{"t", 1'b0, 1'b0, R_ZERO}, '{"-", 1'b0, 1'b0, R_ZERO},
    '{"L", 1'b0, 1'b0, R_ZERO}, '{"e", 1'b0, 1'b0, R_ZERO},
    '{"n", 1'b0, 1'b0, R_ZERO}, '{"g", 1'b0, 1'b0, R_ZERO},
    '{"t", 1'b0, 1'b0, R_ZERO}, '{"h", 1'b0, 1'b0, R_ZERO},
    '{":", 1'b0, 1'b0, R_ZERO}, '{" ", 1'b0, 1'b0, R_ZERO},
    '{CHAR_HT, 1'b0, 1'b0, R_ZERO}, '{"9", 1'b0, 1'b0, R_ZERO},
    '{"x", 1'b0, 1'b0, R_ZERO}, '{CHAR_CR, 1'b0, 1'b1, R_LEN9},
    '{CHAR_LF, 1'b0, 1'b0, R_ZERO}, '{CHAR_CR, 1'b0, 1'b0, R_ZERO},
    '{CHAR_LF, 1'b0, 1'b1, R_HDR9}, '{8'h00, 1'b0, 1'b1, R_BODY1}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          data_byte = 8'h00;
  logic                new_response = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                length_known;
  logic [OUT_BITS-1:0] content_length;
  logic                header_done;
  logic [OUT_BITS-1:0] payload_count;
  logic                is_payload;
  logic                complete;

  // predictor state
  logic [POS_BITS-1:0]   key_pos;
  phase_t                len_phase;
  logic [COUNT_BITS-1:0] len_acc;
  logic                  len_final;
  term_t                 term_pos;
  logic                  hdrs_over;
  logic [COUNT_BITS-1:0] body_bytes;

  result_t    pending_results [$];
  logic [7:0] resp_bytes [$];
  int         bytes_sent = 0;
  int         beats_seen = 0;
  int         mismatches = 0;
  int         send_idle_pct = 24;
  int         recv_stall_pct = 56;

  http_response_length_tracker u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .new_response   (new_response),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .length_known   (length_known),
    .content_length (content_length),
    .header_done    (header_done),
    .payload_count  (payload_count),
    .is_payload     (is_payload),
    .complete       (complete)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void clear_tracker();
    key_pos    = '0;
    len_phase  = PH_MATCH;
    len_acc    = '0;
    len_final  = 1'b0;
    term_pos   = TM_NONE;
    hdrs_over  = 1'b0;
    body_bytes = '0;
  endfunction

  function automatic logic [OUT_BITS-1:0] sat_out(input logic [COUNT_BITS-1:0] v);
    if (64'(v) > 64'(OUT_MAX)) begin
      return OUT_MAX;
    end
    return OUT_BITS'(v);
  endfunction

  // advances the tracker state by one byte, returns the result beat
  function automatic result_t track_byte(input logic [7:0] c, input logic clear);
    logic [63:0]           digit;
    logic                  blank;
    logic                  payload;
    logic [COUNT_BITS-1:0] shown;
    result_t               r;
    if (clear) begin
      clear_tracker();
    end
    blank = (c == CHAR_SP) || (c == CHAR_HT) || (c == CHAR_LF) ||
            (c == CHAR_VT) || (c == CHAR_FF);
    if (!len_final) begin
      if (len_phase == PH_MATCH) begin
        if (key_pos < KEY_LEN && c == KEY_TEXT[key_pos[IDX_BITS-1:0]]) begin
          key_pos = key_pos + 1'b1;
        end else begin
          // no self-overlap in the key: restart on its first letter only
          key_pos = (c == KEY_TEXT[0]) ? POS_BITS'(1) : '0;
        end
        if (key_pos >= KEY_LEN) begin
          len_phase = PH_BLANKS;
        end
      end else if (c == CHAR_CR) begin
        len_final = 1'b1;
      end else if (len_phase != PH_IGNORE) begin
        if (c >= CHAR_0 && c <= CHAR_9) begin
          digit = 64'(c - CHAR_0);
          if (64'(len_acc) > (64'(CNT_MAX) - digit) / 10) begin
            len_acc = CNT_MAX;
          end else begin
            len_acc = COUNT_BITS'(64'(len_acc) * 10 + digit);
          end
          len_phase = PH_DIGITS;
        end else if (!(len_phase == PH_BLANKS && blank)) begin
          len_phase = PH_IGNORE;
        end
      end
    end
    payload = hdrs_over;
    if (hdrs_over) begin
      if (body_bytes != CNT_MAX) begin
        body_bytes = body_bytes + 1'b1;
      end
    end else begin
      if (term_pos == TM_NONE && c == CHAR_CR) begin
        term_pos = TM_CR1;
      end else if (term_pos == TM_CR1 && c == CHAR_LF) begin
        term_pos = TM_LF1;
      end else if (term_pos == TM_LF1 && c == CHAR_CR) begin
        term_pos = TM_CR2;
      end else if (term_pos == TM_CR2 && c == CHAR_LF) begin
        term_pos = TM_LF2;
      end else begin
        term_pos = (c == CHAR_CR) ? TM_CR1 : TM_NONE;
      end
      if (term_pos == TM_LF2) begin
        hdrs_over = 1'b1;
      end
    end
    shown = len_final ? len_acc : '0;
    r.length_known   = len_final;
    r.content_length = sat_out(shown);
    r.header_done    = hdrs_over;
    r.payload_count  = sat_out(body_bytes);
    r.is_payload     = payload;
    r.complete       = len_final && hdrs_over && (body_bytes >= shown);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH beat %0d: %s", beats_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [OUT_BITS-1:0] got,
                             input logic [OUT_BITS-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  // presents one byte, waits for acceptance, then records the expected beat
  task automatic send_byte(input logic [7:0] c, input logic clear,
                           input logic typed, input result_t want);
    result_t predicted;
    int      mix;
    mix = bytes_sent * 3 / TOTAL_BYTES;
    send_idle_pct  = (mix == 0) ? 24 : (mix == 1) ? 56 : 0;
    recv_stall_pct = (mix == 0) ? 56 : (mix == 1) ? 24 : 0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= c;
    new_response <= clear;
    do begin
      @(posedge clk);
    end while (in_stall);
    predicted = track_byte(c, clear);
    pending_results = {pending_results, (typed ? want : predicted)};
    bytes_sent++;
  endtask

  function automatic void add_byte(input logic [7:0] b);
    resp_bytes = {resp_bytes, b};
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_byte(s[i]);
    end
  endfunction

  function automatic void push_crlf();
    add_byte(CHAR_CR);
    add_byte(CHAR_LF);
  endfunction

  function automatic void push_key(input int corrupt_at);
    for (int i = 0; i < KEY_LEN; i++) begin
      add_byte((i == corrupt_at) ? 8'($urandom_range(0, 255)) : KEY_TEXT[i]);
    end
  endfunction

  // builds one response: mostly well-formed headers with random content,
  // some with a broken key, overflowing or missing digits, or pure noise
  function automatic void build_response();
    int       kind;
    int       digit_mode;
    int       body_len;
    logic [7:0] blanks [5];
    blanks = '{CHAR_SP, CHAR_HT, CHAR_VT, CHAR_FF, CHAR_LF};
    resp_bytes.delete();
    kind = $urandom_range(0, 11);
    if (kind == 0) begin
      repeat ($urandom_range(1, 40)) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    push_text("HTTP/1.1 200 OK");
    push_crlf();
    if ($urandom_range(0, 2) == 0) begin
      push_text("X-Tag: ");
      repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(33, 126)));
      push_crlf();
    end
    body_len = $urandom_range(0, 20);
    if (kind != 1) begin
      push_key((kind == 2) ? $urandom_range(0, KEY_LEN - 1) : -1);
      repeat ($urandom_range(0, 2)) begin
        add_byte(blanks[$urandom_range(0, (kind == 3) ? 4 : 3)]);
      end
      digit_mode = $urandom_range(0, 9);
      if (digit_mode == 0) begin
        add_byte(8'($urandom_range(33, 126)));
      end else if (digit_mode == 1) begin
        // 9 to 14 digits: the longer runs pass the counter range and saturate
        repeat ($urandom_range(9, 14)) add_byte(CHAR_0 + 8'($urandom_range(0, 9)));
      end else begin
        body_len = $urandom_range(0, 40);
        push_text($sformatf("%0d", body_len));
      end
      if ($urandom_range(0, 3) == 0) begin
        push_text("; q=1 7");
      end
      push_crlf();
      if ($urandom_range(0, 4) == 0) begin
        push_text("Content-Length: 3");
        push_crlf();
      end
    end
    push_crlf();
    body_len = body_len + $urandom_range(0, 3) - 1;
    if (kind == 1 && $urandom_range(0, 1) == 0) begin
      // header missing: the key only turns up inside the payload
      push_key(-1);
      push_text("5");
      push_crlf();
    end
    for (int i = 0; i < body_len; i++) begin
      add_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_results.pop_front();
        check_field("length_known", 31'(length_known), 31'(want.length_known));
        check_field("content_length", content_length, want.content_length);
        check_field("header_done", 31'(header_done), 31'(want.header_done));
        check_field("payload_count", payload_count, want.payload_count);
        check_field("is_payload", 31'(is_payload), 31'(want.is_payload));
        check_field("complete", 31'(complete), 31'(want.complete));
      end
      beats_seen++;
    end
  end

  initial begin
    logic first;
    clear_tracker();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_table[i]) begin
      send_byte(dir_table[i].data, dir_table[i].clear, dir_table[i].typed,
                dir_table[i].want);
    end
    while (bytes_sent < TOTAL_BYTES) begin
      build_response();
      first = 1'b1;
      foreach (resp_bytes[i]) begin
        send_byte(resp_bytes[i],
                  first ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 199) == 0),
                  1'b0, R_ZERO);
        first = 1'b0;
      end
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
